// ===== src/trm_pkg.sv =====
// shared types and constants for the transmit descriptor ring manager
package trm_pkg;

  localparam int MAX_SLOTS_DEF = 64;
  localparam int Q_DEPTH = 2;
  localparam int Q_AW = $clog2(Q_DEPTH);

  localparam logic [6:0]  RING_SLOTS_RST = 7'd64;
  localparam logic [7:0]  KICK_THRESH_RST = 8'd4;
  localparam logic [15:0] MIN_FRAME = 16'd60;
  localparam logic [15:0] MAX_FRAME = 16'd1518;
  localparam int          FREE_MAX = 63;

  typedef enum logic [1:0] {
    CMD_SUBMIT  = 2'd0,
    CMD_DONE    = 2'd1,
    CMD_RECLAIM = 2'd2,
    CMD_DRAIN   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_ARGS = 2'd1,
    ST_BAD_LEN  = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic [0:0] {
    CFG_RING_SLOTS  = 1'b0,
    CFG_KICK_THRESH = 1'b1
  } cfg_idx_t;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_WALK = 1'b1
  } back_state_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [31:0] buffer_addr;
    logic [15:0] frame_len;
    logic [11:0] vlan_id;
    logic [15:0] port_list;
    logic [15:0] tx_flags;
    logic [5:0]  done_slot;
  } req_t;

  typedef struct packed {
    status_t     status;
    logic [5:0]  slot;
    logic [31:0] desc_addr;
    logic [10:0] desc_len;
    logic [11:0] desc_vlan;
    logic [5:0]  desc_ports;
    logic [15:0] desc_flags;
    logic        ring_idle;
    logic        kick;
    logic [5:0]  free_slots;
    logic [5:0]  reclaimed_pkts;
    logic [16:0] reclaimed_bytes;
  } res_t;

  // classified word passed from front to back
  typedef struct packed {
    cmd_t        cmd;
    status_t     status;
    logic [31:0] addr;
    logic [10:0] raw_len;
    logic [10:0] pad_len;
    logic [11:0] vlan;
    logic [5:0]  ports;
    logic [15:0] flags;
    logic [5:0]  done_slot;
    logic        done_ok;
  } ent_t;

endpackage

// ===== src/trm_front.sv =====
// front end: accepts commands and checks submit arguments
module trm_front import trm_pkg::*; #(
  parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
  input  logic start,
  input  req_t req,
  input  logic full,
  output logic busy,
  output logic push,
  output ent_t ent
);

  logic [15:0] plen;

  assign busy = full;
  assign push = start && !full;
  assign plen = (req.frame_len < MIN_FRAME) ? MIN_FRAME : req.frame_len;

  always_comb begin
    ent.cmd       = req.cmd;
    ent.addr      = req.buffer_addr;
    ent.raw_len   = req.frame_len[10:0];
    ent.pad_len   = plen[10:0];
    ent.vlan      = req.vlan_id;
    ent.ports     = req.port_list[5:0];
    ent.flags     = req.tx_flags;
    ent.done_slot = req.done_slot;
    ent.done_ok   = (32'(req.done_slot) < 32'(MAX_SLOTS));
    if (req.buffer_addr == 32'd0 || req.frame_len == 16'd0) begin
      ent.status = ST_BAD_ARGS;
    end else if (plen > MAX_FRAME) begin
      ent.status = ST_BAD_LEN;
    end else begin
      ent.status = ST_OK;
    end
  end

endmodule

// ===== src/trm_fifo.sv =====
// short queue of classified words between front and back
module trm_fifo import trm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  ent_t wr_ent,
  input  logic pop,
  output ent_t rd_ent,
  output logic empty,
  output logic full
);

  ent_t                ents [Q_DEPTH];
  logic [Q_AW-1:0]     wr_ptr;
  logic [Q_AW-1:0]     rd_ptr;
  logic [Q_AW:0]       count;

  assign empty  = (count == '0);
  assign full   = (count == (Q_AW+1)'(Q_DEPTH));
  assign rd_ent = ents[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (32'(wr_ptr) == Q_DEPTH - 1) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (32'(rd_ptr) == Q_DEPTH - 1) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ents[wr_ptr] <= wr_ent;
    end
  end

endmodule

// ===== src/trm_back.sv =====
// back end: ring state, descriptor issue, kick coalescing and reclaim walk
module trm_back import trm_pkg::*; #(
  parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [6:0] ring_slots,
  input  logic [7:0] kick_threshold,
  input  ent_t       hd,
  input  logic       q_empty,
  output logic       pop,
  output logic       done,
  output res_t       result
);

  localparam int IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int NW = $clog2(MAX_SLOTS + 1);
  localparam int SW = (NW + 2 > 8) ? NW + 2 : 8;

  back_state_t state, state_next;

  logic [IW-1:0]        prod, prod_next;
  logic [IW-1:0]        cons, cons_next;
  logic [7:0]           pend, pend_next;
  logic [MAX_SLOTS-1:0] owned;
  logic [NW-1:0]        steps, steps_next;
  logic [5:0]           pkts, pkts_next;
  logic [16:0]          bytes, bytes_next;
  logic [10:0]          lens [MAX_SLOTS];
  logic [10:0]          rd_len;

  logic [NW-1:0] n;
  logic [NW-1:0] prod_inc, cons_inc;
  logic [IW-1:0] prod_adv, cons_adv;
  logic [7:0]    pend_inc;
  logic          walk_go;
  logic          set_own, clr_own, wr_len;
  logic          res_set;
  res_t          res_next;
  res_t          hold;
  res_t          res_out;
  logic          hold_valid;

  logic signed [SW-1:0] sn, sp, sc, used, fr;
  logic [5:0]           free_cnt;

  // effective ring size
  always_comb begin
    if (ring_slots < 7'd2) begin
      n = NW'(2);
    end else if (32'(ring_slots) > 32'(MAX_SLOTS)) begin
      n = NW'(MAX_SLOTS);
    end else begin
      n = NW'(ring_slots);
    end
  end

  assign prod_inc = NW'(prod) + 1'b1;
  assign cons_inc = NW'(cons) + 1'b1;
  assign prod_adv = (prod_inc >= n) ? '0 : IW'(prod_inc);
  assign cons_adv = (cons_inc >= n) ? '0 : IW'(cons_inc);
  assign pend_inc = pend + 8'd1;
  assign walk_go  = (steps < n) && (cons != prod) && !owned[cons];

  // next state
  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (!q_empty && hd.cmd == CMD_RECLAIM) begin
          state_next = BK_WALK;
        end
      end
      BK_WALK: begin
        if (!walk_go) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    pop        = (state == BK_IDLE) && !q_empty;
    prod_next  = prod;
    cons_next  = cons;
    pend_next  = pend;
    steps_next = steps;
    pkts_next  = pkts;
    bytes_next = bytes;
    set_own    = 1'b0;
    clr_own    = 1'b0;
    wr_len     = 1'b0;
    res_set    = 1'b0;
    res_next   = '0;
    case (state)
      BK_IDLE: begin
        if (pop) begin
          res_set = (hd.cmd != CMD_RECLAIM);
          case (hd.cmd)
            CMD_SUBMIT: begin
              res_next.status = hd.status;
              if (hd.status == ST_OK) begin
                if (prod_adv == cons) begin
                  res_next.status = ST_FULL;
                end else begin
                  set_own             = 1'b1;
                  wr_len              = 1'b1;
                  prod_next           = prod_adv;
                  res_next.slot       = 6'(prod);
                  res_next.desc_addr  = hd.addr;
                  res_next.desc_len   = hd.pad_len;
                  res_next.desc_vlan  = hd.vlan;
                  res_next.desc_ports = hd.ports;
                  res_next.desc_flags = hd.flags;
                  res_next.ring_idle  = (prod == cons);
                  if (prod == cons) begin
                    pend_next     = 8'd0;
                    res_next.kick = 1'b1;
                  end else if (pend_inc >= kick_threshold) begin
                    pend_next     = 8'd0;
                    res_next.kick = 1'b1;
                  end else begin
                    pend_next = pend_inc;
                  end
                end
              end
            end
            CMD_DONE: begin
              clr_own = hd.done_ok;
            end
            CMD_RECLAIM: begin
              steps_next = '0;
              pkts_next  = '0;
              bytes_next = '0;
            end
            default: begin
              if (pend != 8'd0) begin
                pend_next     = 8'd0;
                res_next.kick = 1'b1;
              end
            end
          endcase
        end
      end
      BK_WALK: begin
        if (walk_go) begin
          pkts_next  = pkts + 6'd1;
          bytes_next = bytes + 17'(rd_len);
          cons_next  = cons_adv;
          steps_next = steps + 1'b1;
        end else begin
          res_set                  = 1'b1;
          res_next.reclaimed_pkts  = pkts;
          res_next.reclaimed_bytes = bytes;
        end
      end
      default: begin
        res_set = 1'b0;
      end
    endcase
  end

  // free slots from the settled ring state
  always_comb begin
    sn   = signed'(SW'(n));
    sp   = signed'(SW'(prod));
    sc   = signed'(SW'(cons));
    used = (sp >= sc) ? (sp - sc) : (sn - sc + sp);
    fr   = sn - signed'(SW'(1)) - used;
    if (fr < signed'(SW'(0))) begin
      free_cnt = 6'd0;
    end else if (fr > signed'(SW'(FREE_MAX))) begin
      free_cnt = 6'(FREE_MAX);
    end else begin
      free_cnt = 6'(fr);
    end
  end

  always_comb begin
    res_out            = hold;
    res_out.free_slots = free_cnt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= BK_IDLE;
      prod       <= '0;
      cons       <= '0;
      pend       <= '0;
      owned      <= '0;
      hold_valid <= 1'b0;
      done       <= 1'b0;
    end else begin
      state      <= state_next;
      prod       <= prod_next;
      cons       <= cons_next;
      pend       <= pend_next;
      hold_valid <= res_set;
      done       <= hold_valid;
      if (set_own) begin
        owned[prod] <= 1'b1;
      end
      if (clr_own) begin
        owned[IW'(hd.done_slot)] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    steps <= steps_next;
    pkts  <= pkts_next;
    bytes <= bytes_next;
    if (res_set) begin
      hold <= res_next;
    end
    result <= res_out;
  end

  // unpadded length store
  always_ff @(posedge clk) begin
    if (wr_len) begin
      lens[prod] <= hd.raw_len;
    end
    rd_len <= lens[cons_next];
  end

endmodule

// ===== src/tx_descriptor_ring_manager.sv =====
// transmit descriptor ring manager top level
//
//  channel   signals                          direction  accepted when
//  command   start, busy, req                 in         start && !busy
//  result    done, result                     out        every cycle done is high
//  config    cfg_valid, cfg_ready,            in         cfg_valid && cfg_ready
//            cfg_index, cfg_data
//
//  submit, hw_done, drain: queue, hold reg, result reg; one per cycle unless walking
//  reclaim: walks from the consumer index until an owned slot or the producer; the walk
//    checks one owned bit and reads one length word per cycle
//  busy is high while the two-word command queue is full
//  synchronous reset; no clearing pass, the block takes commands right after reset
//  the receiver cannot stall: each result is valid for exactly one cycle
module tx_descriptor_ring_manager import trm_pkg::*; #(
  parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  req_t       req,
  output logic       done,
  output res_t       result,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  cfg_idx_t   cfg_index,
  input  logic [7:0] cfg_data
);

  logic [6:0] ring_slots;
  logic [7:0] kick_threshold;

  logic push, pop, q_empty, q_full;
  ent_t wr_ent, hd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_slots     <= RING_SLOTS_RST;
      kick_threshold <= KICK_THRESH_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_RING_SLOTS:  ring_slots     <= cfg_data[6:0];
        CFG_KICK_THRESH: kick_threshold <= cfg_data;
        default:         ring_slots     <= ring_slots;
      endcase
    end
  end

  trm_front #(
    .MAX_SLOTS(MAX_SLOTS)
  ) u_front (
    .start(start),
    .req  (req),
    .full (q_full),
    .busy (busy),
    .push (push),
    .ent  (wr_ent)
  );

  trm_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wr_ent(wr_ent),
    .pop   (pop),
    .rd_ent(hd),
    .empty (q_empty),
    .full  (q_full)
  );

  trm_back #(
    .MAX_SLOTS(MAX_SLOTS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .ring_slots    (ring_slots),
    .kick_threshold(kick_threshold),
    .hd            (hd),
    .q_empty       (q_empty),
    .pop           (pop),
    .done          (done),
    .result        (result)
  );

`ifndef ASSERT_OFF
  a_reject_quiet: assert property (@(posedge clk) disable iff (rst)
    (done && result.status != ST_OK) |-> (!result.kick && result.desc_len == 11'd0))
    else $error("rejected submit carries a descriptor or kick");

  a_len_range: assert property (@(posedge clk) disable iff (rst)
    (done && result.desc_len != 11'd0) |->
      (result.desc_len >= 11'd60 && result.desc_len <= 11'd1518))
    else $error("descriptor length out of range");

  a_empty_kicks: assert property (@(posedge clk) disable iff (rst)
    (done && result.ring_idle) |-> result.kick)
    else $error("submit into empty ring did not kick");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_empty)
    else $error("back end popped an empty queue");
`endif

endmodule
